### rtl/fpa_pkg.sv
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    localparam int DIV_W     = WORD_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               truth;
        logic [1:0]         status;
    } out_item_t;

    // result already resolved for everything except a live divide and, before stage 3, a multiply
    typedef struct packed {
        logic [31:0] result;
        logic        truth;
        status_t     status;
        logic        is_div;
        logic        div_neg;
    } side_t;

    function automatic logic fits32(input logic [63:0] v);
        return v[63:31] == {33{v[31]}};
    endfunction

endpackage

### rtl/fpa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module fpa_div_pipe (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [fpa_pkg::DIV_W-1:0] dvd,
    input  logic [31:0]               dvs,
    input  fpa_pkg::side_t            side_in,
    output logic                      out_valid,
    output logic [fpa_pkg::DIV_W-1:0] quo,
    output fpa_pkg::side_t            side_out
);

    localparam int N = fpa_pkg::DIV_W;

    logic [N-1:0]         valid_reg;
    logic [N-1:0]         work_reg [N];
    logic [31:0]          rem_reg  [N];
    logic [31:0]          dvs_reg  [N];
    fpa_pkg::side_t       side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic           v_in;
        logic [N-1:0]   work_in;
        logic [31:0]    rem_in;
        logic [31:0]    dvs_in;
        fpa_pkg::side_t sd_in;
        logic [32:0]    trial;
        logic [32:0]    diff;
        logic           take;
        logic [31:0]    rem_next;
        logic [N-1:0]   work_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign work_in = dvd;
            assign rem_in  = '0;
            assign dvs_in  = dvs;
            assign sd_in   = side_in;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign work_in = work_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign sd_in   = side_reg[k-1];
        end

        assign trial     = {rem_in, work_in[N-1]};
        assign diff      = trial - {1'b0, dvs_in};
        assign take      = ~diff[32];
        assign rem_next  = take ? diff[31:0] : trial[31:0];
        assign work_next = {work_in[N-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[k] <= work_next;
                rem_reg[k]  <= rem_next;
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quo       = work_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### rtl/fixed_point_q24_8_alu_top.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Fully pipelined: one transaction is taken every cycle while the result side keeps
// up, and each Q24.8 result leaves in order after its transaction passes through
// stages 1 to 3, the divider, the final stage and the output register. That depth
// is set by the restoring divider, which resolves one quotient bit per stage over
// the 32 + FRAC_BITS bit shifted dividend; every operation travels through the same
// stages. A two-entry output buffer keeps op_ready a registered signal: it drops
// only once a result is held and a second one is waiting behind it.
module fixed_point_q24_8_alu_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  fpa_pkg::in_item_t   op,
    output logic                res_valid,
    input  logic                res_ready,
    output fpa_pkg::out_item_t  res
);

    localparam int N = fpa_pkg::DIV_W;

    logic en;

    // stage 1: registered operands
    logic              s1_valid_reg;
    fpa_pkg::in_item_t s1_op_reg;

    // stage 2: product, simple ops, divider operands
    logic                s2_valid_reg;
    logic signed [63:0]  s2_prod_reg;
    logic                s2_is_mul_reg;
    fpa_pkg::side_t      s2_side_reg;
    logic [N-1:0]        s2_dvd_reg;
    logic [31:0]         s2_dvs_reg;

    logic signed [63:0]  s2_prod_next;
    logic                s2_is_mul_next;
    fpa_pkg::side_t      s2_side_next;
    logic [N-1:0]        s2_dvd_next;
    logic [31:0]         s2_dvs_next;

    // stage 3: multiply resolved
    logic                s3_valid_reg;
    fpa_pkg::side_t      s3_side_reg;
    logic [N-1:0]        s3_dvd_reg;
    logic [31:0]         s3_dvs_reg;
    fpa_pkg::side_t      s3_side_next;

    // divider outputs
    logic                dv_valid;
    logic [N-1:0]        dv_quo;
    fpa_pkg::side_t      dv_side;

    // final stage and output buffer
    logic                fin_valid_reg;
    fpa_pkg::out_item_t  fin_reg;
    fpa_pkg::out_item_t  fin_next;
    logic                res_valid_reg;
    fpa_pkg::out_item_t  res_reg;
    logic                skid_valid_reg;
    fpa_pkg::out_item_t  skid_reg;

    logic signed [31:0]  a;
    logic signed [31:0]  b;
    logic signed [32:0]  sum_w;
    logic signed [32:0]  dif_w;
    logic signed [32:0]  inc_w;
    logic signed [32:0]  dec_w;
    logic signed [63:0]  fi_w;
    logic [31:0]         abs_a;
    logic [31:0]         abs_b;
    logic signed [63:0]  mul_sh;
    logic signed [63:0]  div_val;

    assign en       = ~skid_valid_reg;
    assign op_ready = en;

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= op;
        end
    end

    // ---------------- stage 2 ----------------
    assign a      = s1_op_reg.operand_a;
    assign b      = s1_op_reg.operand_b;
    assign sum_w  = 33'(a) + 33'(b);
    assign dif_w  = 33'(a) - 33'(b);
    assign inc_w  = 33'(a) + 33'sd1;
    assign dec_w  = 33'(a) - 33'sd1;
    assign fi_w   = 64'(a) <<< fpa_pkg::FRAC_BITS;
    assign abs_a  = a[31] ? $unsigned(-a) : $unsigned(a);
    assign abs_b  = b[31] ? $unsigned(-b) : $unsigned(b);

    assign s2_prod_next = 64'(a) * 64'(b);
    assign s2_dvd_next  = N'(abs_a) << fpa_pkg::FRAC_BITS;
    assign s2_dvs_next  = abs_b;

    always_comb
    begin
        s2_is_mul_next       = 1'b0;
        s2_side_next         = '0;
        s2_side_next.status  = fpa_pkg::ST_OK;
        s2_side_next.div_neg = a[31] ^ b[31];
        case (fpa_pkg::op_t'(s1_op_reg.mode))
            fpa_pkg::OP_ADD:
            begin
                s2_side_next.result = sum_w[31:0];
                if (sum_w[32] != sum_w[31])
                    s2_side_next.status = fpa_pkg::ST_OVERFLOW;
            end
            fpa_pkg::OP_SUB:
            begin
                s2_side_next.result = dif_w[31:0];
                if (dif_w[32] != dif_w[31])
                    s2_side_next.status = fpa_pkg::ST_OVERFLOW;
            end
            fpa_pkg::OP_MUL:
            begin
                s2_is_mul_next = 1'b1;
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 32'sd0)
                    s2_side_next.status = fpa_pkg::ST_DIV_ZERO;
                else
                    s2_side_next.is_div = 1'b1;
            end
            fpa_pkg::OP_GT: s2_side_next.truth = a > b;
            fpa_pkg::OP_LT: s2_side_next.truth = a < b;
            fpa_pkg::OP_GE: s2_side_next.truth = a >= b;
            fpa_pkg::OP_LE: s2_side_next.truth = a <= b;
            fpa_pkg::OP_EQ: s2_side_next.truth = a == b;
            fpa_pkg::OP_NE: s2_side_next.truth = a != b;
            fpa_pkg::OP_MIN: s2_side_next.result = (a < b) ? a : b;
            fpa_pkg::OP_MAX: s2_side_next.result = (a > b) ? a : b;
            fpa_pkg::OP_INC:
            begin
                s2_side_next.result = inc_w[31:0];
                if (inc_w[32] != inc_w[31])
                    s2_side_next.status = fpa_pkg::ST_OVERFLOW;
            end
            fpa_pkg::OP_DEC:
            begin
                s2_side_next.result = dec_w[31:0];
                if (dec_w[32] != dec_w[31])
                    s2_side_next.status = fpa_pkg::ST_OVERFLOW;
            end
            fpa_pkg::OP_FROM_INT:
            begin
                s2_side_next.result = fi_w[31:0];
                if (!fpa_pkg::fits32(fi_w))
                    s2_side_next.status = fpa_pkg::ST_OVERFLOW;
            end
            fpa_pkg::OP_TO_INT:
            begin
                s2_side_next.result = a >>> fpa_pkg::FRAC_BITS;
            end
            default:
            begin
                s2_side_next.result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_prod_reg   <= s2_prod_next;
            s2_is_mul_reg <= s2_is_mul_next;
            s2_side_reg   <= s2_side_next;
            s2_dvd_reg    <= s2_dvd_next;
            s2_dvs_reg    <= s2_dvs_next;
        end
    end

    // ---------------- stage 3 ----------------
    assign mul_sh = s2_prod_reg >>> fpa_pkg::FRAC_BITS;

    always_comb
    begin
        s3_side_next = s2_side_reg;
        if (s2_is_mul_reg)
        begin
            s3_side_next.result = mul_sh[31:0];
            s3_side_next.status = fpa_pkg::fits32(mul_sh) ? fpa_pkg::ST_OK
                                                          : fpa_pkg::ST_OVERFLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
            s3_dvd_reg  <= s2_dvd_reg;
            s3_dvs_reg  <= s2_dvs_reg;
        end
    end

    // ---------------- divider ----------------
    fpa_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .dvd       (s3_dvd_reg),
        .dvs       (s3_dvs_reg),
        .side_in   (s3_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    // ---------------- final stage ----------------
    assign div_val = dv_side.div_neg ? -$signed(64'(dv_quo)) : $signed(64'(dv_quo));

    always_comb
    begin
        fin_next.result = dv_side.result;
        fin_next.truth  = dv_side.truth;
        fin_next.status = 2'(dv_side.status);
        if (dv_side.is_div)
        begin
            fin_next.result = div_val[31:0];
            fin_next.truth  = 1'b0;
            fin_next.status = fpa_pkg::fits32(div_val) ? 2'(fpa_pkg::ST_OK)
                                                       : 2'(fpa_pkg::ST_OVERFLOW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= fin_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (fin_valid_reg)
        begin
            if (res_valid_reg && !res_ready)
                skid_valid_reg <= 1'b1;
            else
                res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res_ready)
                res_reg <= skid_reg;
        end
        else if (fin_valid_reg)
        begin
            if (res_valid_reg && !res_ready)
                skid_reg <= fin_reg;
            else
                res_reg <= fin_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/fpa_chk.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               op_valid,
    input logic               op_ready,
    input fpa_pkg::in_item_t  op,
    input logic               res_valid,
    input logic               res_ready,
    input fpa_pkg::out_item_t res
);

    // a stalled transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    // backpressure only when a result is waiting
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> res_valid)
        else $error("op_ready low with no result pending");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == 2'(fpa_pkg::ST_DIV_ZERO) |->
            res.result == 32'sd0 && !res.truth)
        else $error("divide by zero result not cleared");

    a_truth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.truth |->
            res.result == 32'sd0 && res.status == 2'(fpa_pkg::ST_OK))
        else $error("comparison result carries data or status");

endmodule

bind fixed_point_q24_8_alu_top fpa_chk u_fpa_chk (.*);

### bench/tb_fixed_point_q24_8_alu_top.sv
// Self-checking testbench for the Q24.8 fixed-point ALU.
module tb_fixed_point_q24_8_alu_top;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00000100;
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        fpa_pkg::in_item_t  op_in;
        fpa_pkg::out_item_t want;
    } pending_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               op_valid;
    logic               op_ready;
    fpa_pkg::in_item_t  op;
    logic               res_valid;
    logic               res_ready;
    fpa_pkg::out_item_t res;

    pending_t pending_results[$];
    pending_t oldest;
    int       mismatch_count = 0;
    int       burst_left = 0;
    bit       gapless = 1'b0;
    int       hold_request = 0;

    fixed_point_q24_8_alu_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic fpa_pkg::out_item_t fixed_point_result(input fpa_pkg::in_item_t item);
        longint             a;
        longint             b;
        longint             r;
        logic               truth;
        fpa_pkg::status_t   status;
        bit                 arith;
        fpa_pkg::out_item_t o;
        a      = longint'($signed(item.operand_a));
        b      = longint'($signed(item.operand_b));
        r      = 0;
        truth  = 1'b0;
        status = fpa_pkg::ST_OK;
        arith  = 1'b0;
        case (fpa_pkg::op_t'(item.mode))
            fpa_pkg::OP_ADD:
            begin
                r     = a + b;
                arith = 1'b1;
            end
            fpa_pkg::OP_SUB:
            begin
                r     = a - b;
                arith = 1'b1;
            end
            fpa_pkg::OP_MUL:
            begin
                r     = (a * b) >>> fpa_pkg::FRAC_BITS;
                arith = 1'b1;
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 0)
                    status = fpa_pkg::ST_DIV_ZERO;
                else
                begin
                    r     = (a <<< fpa_pkg::FRAC_BITS) / b;
                    arith = 1'b1;
                end
            end
            fpa_pkg::OP_GT:  truth = a > b;
            fpa_pkg::OP_LT:  truth = a < b;
            fpa_pkg::OP_GE:  truth = a >= b;
            fpa_pkg::OP_LE:  truth = a <= b;
            fpa_pkg::OP_EQ:  truth = a == b;
            fpa_pkg::OP_NE:  truth = a != b;
            fpa_pkg::OP_MIN: r = (a < b) ? a : b;
            fpa_pkg::OP_MAX: r = (a > b) ? a : b;
            fpa_pkg::OP_INC:
            begin
                r     = a + 1;
                arith = 1'b1;
            end
            fpa_pkg::OP_DEC:
            begin
                r     = a - 1;
                arith = 1'b1;
            end
            fpa_pkg::OP_FROM_INT:
            begin
                r     = a <<< fpa_pkg::FRAC_BITS;
                arith = 1'b1;
            end
            default:         r = a >>> fpa_pkg::FRAC_BITS;
        endcase
        if (arith && (r > WORD_HI || r < WORD_LO))
            status = fpa_pkg::ST_OVERFLOW;
        o.result = r[31:0];
        o.truth  = truth;
        o.status = status;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input fpa_pkg::in_item_t item,
                                   input longint got, input longint want);
        $display("mismatch %s: mode %0d a %h b %h got %h want %h", field, item.mode,
                 item.operand_a, item.operand_b, got, want);
        mismatch_count++;
    endtask

    // one transaction; valid stays high afterward unless the next call opens a gap
    task automatic send_op(input fpa_pkg::op_t mode, input logic signed [31:0] a,
                           input logic signed [31:0] b);
        fpa_pkg::in_item_t item;
        pending_t          p;
        int                gap;
        item.mode      = mode;
        item.operand_a = a;
        item.operand_b = b;
        if (burst_left == 0)
        begin
            gap = gapless ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                op_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        op       <= item;
        op_valid <= 1'b1;
        do @(posedge clk); while (!op_ready);
        p.op_in = item;
        p.want  = fixed_point_result(item);
        pending_results.push_back(p);
        burst_left--;
    endtask

    function automatic logic signed [31:0] random_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom;
        else if (pick < 60)
            return $signed($urandom_range(0, 2047)) - 1024;
        else if (pick < 75)
            return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
        else
        begin
            case ($urandom_range(0, 7))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return 0;
                3:       return -1;
                4:       return 1;
                5:       return Q_ONE;
                6:       return -Q_ONE;
                default: return 32'sh00800000;
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected", '0, res.result, 0);
            else
            begin
                oldest = pending_results.pop_front();
                if (res.result !== oldest.want.result)
                    report_mismatch("result", oldest.op_in, res.result, oldest.want.result);
                if (res.truth !== oldest.want.truth)
                    report_mismatch("truth", oldest.op_in, res.truth, oldest.want.truth);
                if (res.status !== oldest.want.status)
                    report_mismatch("status", oldest.op_in, res.status, oldest.want.status);
            end
        end
    end

    // result side: randomly chosen stall styles, long hold-off on request
    initial
    begin
        int style;
        int cycle;
        int hold_left;
        style     = 0;
        cycle     = 0;
        hold_left = 0;
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (cycle % 50 == 0)
                style = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (style)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= $urandom_range(0, 1);
                    2:       res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= ((cycle % 8) < 5);
                endcase
            end
        end
    end

    task automatic test_arith_edges();
        send_op(fpa_pkg::OP_ADD, Q_MAX, 1);
        send_op(fpa_pkg::OP_ADD, Q_MIN, Q_MIN);
        send_op(fpa_pkg::OP_SUB, Q_MIN, 1);
        send_op(fpa_pkg::OP_SUB, 0, Q_MIN);
        send_op(fpa_pkg::OP_INC, Q_MAX, 0);
        send_op(fpa_pkg::OP_DEC, Q_MIN, 0);
        send_op(fpa_pkg::OP_FROM_INT, 32'sh00800000, 0);
        send_op(fpa_pkg::OP_FROM_INT, -32'sh00800000, 0);
        send_op(fpa_pkg::OP_TO_INT, Q_MIN, 0);
        send_op(fpa_pkg::OP_TO_INT, -1, Q_MAX);
    endtask

    task automatic test_mul_div_edges();
        send_op(fpa_pkg::OP_MUL, Q_MAX, Q_MAX);
        send_op(fpa_pkg::OP_MUL, -1, 1);
        send_op(fpa_pkg::OP_MUL, Q_ONE, Q_ONE);
        send_op(fpa_pkg::OP_DIV, Q_MAX, 0);
        send_op(fpa_pkg::OP_DIV, Q_MIN, -1);
        send_op(fpa_pkg::OP_DIV, -1, 3);
        send_op(fpa_pkg::OP_DIV, Q_ONE, 32'sh300);
    endtask

    task automatic test_compare_edges();
        send_op(fpa_pkg::OP_GT, Q_MAX, Q_MIN);
        send_op(fpa_pkg::OP_LT, Q_MIN, Q_MAX);
        send_op(fpa_pkg::OP_GE, -5, -5);
        send_op(fpa_pkg::OP_LE, Q_MAX, Q_MAX);
        send_op(fpa_pkg::OP_EQ, Q_MIN, Q_MIN);
        send_op(fpa_pkg::OP_NE, 7, 7);
        send_op(fpa_pkg::OP_MIN, -3, -3);
        send_op(fpa_pkg::OP_MAX, Q_MIN, Q_MAX);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] a;
        logic signed [31:0] b;
        repeat (count)
        begin
            a = random_operand();
            b = ($urandom_range(0, 9) == 0) ? a : random_operand();
            send_op(fpa_pkg::op_t'($urandom_range(0, 15)), a, b);
        end
    endtask

    // result side held off while transactions keep coming, so the pipe fills
    task automatic test_backpressure(input int count);
        gapless      = 1'b1;
        burst_left   = 0;
        hold_request = 300;
        repeat (count)
            send_op(fpa_pkg::op_t'($urandom_range(0, 15)), random_operand(),
                    random_operand());
        gapless = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        op_valid = 1'b0;
        op       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_arith_edges();
        test_mul_div_edges();
        test_compare_edges();
        test_random(1650);
        test_backpressure(60);
        test_random(40);
        op_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/fpa_pkg.sv
rtl/fpa_div_pipe.sv
rtl/fixed_point_q24_8_alu_top.sv
rtl/fpa_chk.sv
bench/tb_fixed_point_q24_8_alu_top.sv
